// ===== design/pte_pkg.sv =====
// shared types and constants of the permutation table engine
package pte_pkg;

  // fixed field widths
  localparam int unsigned VAL_W = 8;
  localparam int unsigned CNT_W = 9;
  localparam int unsigned MODE_W = 3;
  localparam logic [CNT_W-1:0] POINTS_RESET = 9'd256;

  // request modes, codes 6 and 7 are unused
  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_OWN   = 3'd0,
    MODE_LOAD_OTHER = 3'd1,
    MODE_IDENTITY   = 3'd2,
    MODE_INVERT     = 3'd3,
    MODE_COMPOSE    = 3'd4,
    MODE_QUERY      = 3'd5
  } mode_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QUERY,
    ST_WALK,
    ST_FLUSH
  } seq_state_e;

  // sequencer to datapath control
  typedef struct packed {
    logic             idle;
    mode_e            mode;
    logic             issue_vld;
    logic [CNT_W-1:0] issue_idx;
    logic             s1_vld;
    logic [CNT_W-1:0] s1_idx;
    logic             s2_vld;
    logic [CNT_W-1:0] s2_idx;
    logic             done;
    logic             done_query;
  } seq_ctrl_t;

endpackage

// ===== design/pte_ram.sv =====
// single write port, single registered read port table memory
module pte_ram #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned DATA_W = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/pte_seq.sv =====
// sequencer that serves queries and walks the table for identity, invert and compose
module pte_seq (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_query_i,
  input  logic                    start_walk_i,
  input  pte_pkg::mode_e          mode_i,
  input  logic [pte_pkg::CNT_W-1:0] points_i,
  output pte_pkg::seq_ctrl_t      ctrl_o
);
  import pte_pkg::*;

  seq_state_e       state_q, state_d;
  logic [CNT_W-1:0] walk_q, walk_d;
  mode_e            mode_q;
  logic             s1_vld_q, s2_vld_q;
  logic [CNT_W-1:0] s1_idx_q, s2_idx_q;
  logic             issue_vld;
  logic             done, done_query;

  // state register and walk counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      walk_q   <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      walk_q   <= walk_d;
      s1_vld_q <= issue_vld;
      s2_vld_q <= s1_vld_q && (mode_q == MODE_COMPOSE);
    end
  end

  // walk payload, no reset needed
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && start_walk_i) begin
      mode_q <= mode_i;
    end
    s1_idx_q <= walk_q;
    s2_idx_q <= s1_idx_q;
  end

  // next state and outputs
  always_comb begin
    state_d    = state_q;
    walk_d     = walk_q;
    issue_vld  = 1'b0;
    done       = 1'b0;
    done_query = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_query_i) begin
          state_d = ST_QUERY;
        end else if (start_walk_i) begin
          state_d = ST_WALK;
          walk_d  = '0;
        end
      end
      ST_QUERY: begin
        done       = 1'b1;
        done_query = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_WALK: begin
        issue_vld = 1'b1;
        if (walk_q == points_i - CNT_W'(1)) begin
          walk_d  = '0;
          state_d = ST_FLUSH;
        end else begin
          walk_d = walk_q + CNT_W'(1);
        end
      end
      ST_FLUSH: begin
        if (!s1_vld_q && !s2_vld_q) begin
          done    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign ctrl_o.idle       = (state_q == ST_IDLE);
  assign ctrl_o.mode       = mode_q;
  assign ctrl_o.issue_vld  = issue_vld;
  assign ctrl_o.issue_idx  = walk_q;
  assign ctrl_o.s1_vld     = s1_vld_q;
  assign ctrl_o.s1_idx     = s1_idx_q;
  assign ctrl_o.s2_vld     = s2_vld_q;
  assign ctrl_o.s2_idx     = s2_idx_q;
  assign ctrl_o.done       = done;
  assign ctrl_o.done_query = done_query;

endmodule

// ===== design/permutation_table_engine.sv =====
// permutation table engine top level: tables, shared compare and result register
//
//   channel   direction  payload (lowest bit first)
//   s_axis    in         tdata: point_index[7:0], entry_value[15:8]; tuser: mode[2:0]
//   m_axis    out        tdata: image_value[7:0], status[8], zero[15:9]
//   cfg       in         data: point_count[8:0]
//
// loads, unused modes, empty walks and out-of-range queries are answered directly.
// identity, invert and compose walk the active bank one point a cycle through
// the single table read port, and no new request is taken meanwhile.
// a request is taken only while the result register is empty or being drained.
// reset leaves the tables; it clears bank select and sets point_count to 256.
module permutation_table_engine #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // point_index, entry_value
  input  logic [2:0]  s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // image_value, status, zero fill
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [8:0]  cfg_data_i
);
  import pte_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned N_CLIP = (MAX_POINTS > 511) ? 511 : MAX_POINTS;

  logic [CNT_W-1:0] points_q;
  logic [CNT_W-1:0] n_eff;
  logic             sel_q;
  logic             out_vld_q;
  logic [VAL_W-1:0] out_img_q;
  logic             out_stat_q;
  logic             s2_ok_q;

  mode_e            in_mode;
  logic [VAL_W-1:0] in_idx, in_val;
  logic             accept;
  logic             imm_fill, imm_stat;
  logic             start_query, start_walk;
  logic             n_zero;
  seq_ctrl_t        ctrl;

  logic [VAL_W-1:0] cmp_a;
  logic             cmp_lt;

  logic             img_we;
  logic [IDX_W:0]   img_waddr, img_raddr;
  logic [VAL_W-1:0] img_wdata, img_rdata;
  logic             oth_we;
  logic [IDX_W-1:0] oth_waddr, oth_raddr;
  logic [VAL_W-1:0] oth_wdata, oth_rdata;

  assign in_mode = mode_e'(s_axis_tuser);
  assign in_idx  = s_axis_tdata[7:0];
  assign in_val  = s_axis_tdata[15:8];

  // point count register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q <= POINTS_RESET;
    end else if (cfg_valid_i) begin
      points_q <= cfg_data_i;
    end
  end

  assign n_eff  = (points_q > CNT_W'(N_CLIP)) ? CNT_W'(N_CLIP) : points_q;
  assign n_zero = (n_eff == '0);

  // shared range compare: request index when idle, table entry during a walk
  assign cmp_a  = ctrl.idle ? in_idx : img_rdata;
  assign cmp_lt = ({1'b0, cmp_a} < n_eff);

  // request handshake
  assign s_axis_tready = ctrl.idle && (!out_vld_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // request decode
  always_comb begin
    imm_fill    = 1'b0;
    imm_stat    = 1'b0;
    start_query = 1'b0;
    start_walk  = 1'b0;
    if (accept) begin
      unique case (in_mode)
        MODE_LOAD_OWN, MODE_LOAD_OTHER: begin
          imm_fill = 1'b1;
          imm_stat = !cmp_lt;
        end
        MODE_QUERY: begin
          if (cmp_lt) begin
            start_query = 1'b1;
          end else begin
            imm_fill = 1'b1;
            imm_stat = 1'b1;
          end
        end
        MODE_IDENTITY, MODE_INVERT, MODE_COMPOSE: begin
          if (n_zero) begin
            imm_fill = 1'b1;
          end else begin
            start_walk = 1'b1;
          end
        end
        default: imm_fill = 1'b1;
      endcase
    end
  end

  pte_seq u_seq (
    .clk_i,
    .rst_ni,
    .start_query_i (start_query),
    .start_walk_i  (start_walk),
    .mode_i        (in_mode),
    .points_i      (n_eff),
    .ctrl_o        (ctrl)
  );

  // image table write port
  always_comb begin
    img_we    = 1'b0;
    img_waddr = {sel_q, IDX_W'(in_idx)};
    img_wdata = in_val;
    if (accept && (in_mode == MODE_LOAD_OWN) && cmp_lt) begin
      img_we = 1'b1;
    end else if (ctrl.issue_vld && (ctrl.mode == MODE_IDENTITY)) begin
      img_we    = 1'b1;
      img_waddr = {sel_q, IDX_W'(ctrl.issue_idx)};
      img_wdata = ctrl.issue_idx[VAL_W-1:0];
    end else if (ctrl.s1_vld && (ctrl.mode == MODE_INVERT) && cmp_lt) begin
      img_we    = 1'b1;
      img_waddr = {~sel_q, IDX_W'(img_rdata)};
      img_wdata = ctrl.s1_idx[VAL_W-1:0];
    end else if (ctrl.s2_vld && s2_ok_q) begin
      img_we    = 1'b1;
      img_waddr = {sel_q, IDX_W'(ctrl.s2_idx)};
      img_wdata = oth_rdata;
    end
  end

  // image table read address: walk position or queried point
  assign img_raddr = ctrl.issue_vld ? {sel_q, IDX_W'(ctrl.issue_idx)}
                                    : {sel_q, IDX_W'(in_idx)};

  // two banks, each padded to a power of two so the bank bit heads the address
  pte_ram #(
    .DEPTH  (2 ** (IDX_W + 1)),
    .DATA_W (VAL_W)
  ) u_img_ram (
    .clk_i,
    .we_i    (img_we),
    .waddr_i (img_waddr),
    .wdata_i (img_wdata),
    .raddr_i (img_raddr),
    .rdata_o (img_rdata)
  );

  // other table
  assign oth_we    = accept && (in_mode == MODE_LOAD_OTHER) && cmp_lt;
  assign oth_waddr = IDX_W'(in_idx);
  assign oth_wdata = in_val;
  assign oth_raddr = IDX_W'(img_rdata);

  pte_ram #(
    .DEPTH  (MAX_POINTS),
    .DATA_W (VAL_W)
  ) u_oth_ram (
    .clk_i,
    .we_i    (oth_we),
    .waddr_i (oth_waddr),
    .wdata_i (oth_wdata),
    .raddr_i (oth_raddr),
    .rdata_o (oth_rdata)
  );

  // compose keeps entries whose value is out of range
  always_ff @(posedge clk_i) begin
    s2_ok_q <= cmp_lt;
  end

  // bank select flips at the end of an inversion
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else if (ctrl.done && !ctrl.done_query && (ctrl.mode == MODE_INVERT)) begin
      sel_q <= ~sel_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (imm_fill || ctrl.done) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (imm_fill) begin
      out_img_q  <= '0;
      out_stat_q <= imm_stat;
    end else if (ctrl.done) begin
      out_img_q  <= ctrl.done_query ? img_rdata : '0;
      out_stat_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_stat_q, out_img_q};

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench of the permutation table engine
module tb;
  import pte_pkg::*;

  localparam int unsigned TABLE_POINTS = 256;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS = 60;
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  typedef struct {
    logic [VAL_W-1:0] image;
    logic             status;
  } image_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // point_index[7:0], entry_value[15:8]
  logic [2:0]  s_axis_tuser = '0;  // mode[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // image_value[7:0], status[8], zero[15:9]
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [8:0]  cfg_data_i = '0;

  // predicted state of the tables
  logic [VAL_W-1:0] bank_img [0:1][0:TABLE_POINTS-1];
  logic             bank_sel = 1'b0;
  logic [VAL_W-1:0] other_img [0:TABLE_POINTS-1];
  logic [CNT_W-1:0] points_cfg = POINTS_RESET;

  image_result_t expected_images[$];
  image_result_t oldest;
  int mismatch_count = 0;
  int items_sent = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  permutation_table_engine #(.MAX_POINTS(TABLE_POINTS)) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // points in use, clipped to the table size
  function automatic int active_count();
    if (points_cfg > TABLE_POINTS) return TABLE_POINTS;
    return int'(points_cfg);
  endfunction

  // applies one request to the predicted tables and queues its result
  function automatic void predict_request(input logic [MODE_W-1:0] mode,
                                          input logic [VAL_W-1:0] idx,
                                          input logic [VAL_W-1:0] val);
    int n;
    int i;
    logic [VAL_W-1:0] img;
    logic [VAL_W-1:0] v;
    logic flag;
    n = active_count();
    img = '0;
    flag = 1'b0;
    case (mode)
      MODE_LOAD_OWN: begin
        if (idx < n) bank_img[bank_sel][idx] = val;
        else flag = 1'b1;
      end
      MODE_LOAD_OTHER: begin
        if (idx < n) other_img[idx] = val;
        else flag = 1'b1;
      end
      MODE_IDENTITY: begin
        for (i = 0; i < n; i++) bank_img[bank_sel][i] = i[VAL_W-1:0];
      end
      MODE_INVERT: begin
        // entries pointing past the count write nothing
        if (n > 0) begin
          for (i = 0; i < n; i++) begin
            v = bank_img[bank_sel][i];
            if (v < n) bank_img[bank_sel ^ 1'b1][v] = i[VAL_W-1:0];
          end
          bank_sel = bank_sel ^ 1'b1;
        end
      end
      MODE_COMPOSE: begin
        for (i = 0; i < n; i++) begin
          v = bank_img[bank_sel][i];
          if (v < n) bank_img[bank_sel][i] = other_img[v];
        end
      end
      MODE_QUERY: begin
        if (idx < n) img = bank_img[bank_sel][idx];
        else flag = 1'b1;
      end
      default: ;
    endcase
    expected_images.push_back('{image: img, status: flag});
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // sends one request, with random idle cycles ahead of it
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [VAL_W-1:0] idx,
                           input logic [VAL_W-1:0] val);
    while (!calm && $urandom_range(99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {val, idx};
    s_axis_tuser <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_request(mode, idx, val);
    items_sent++;
  endtask

  // input pauses until every pending result has come back
  task automatic drain_results;
    s_axis_tvalid <= 1'b0;
    while (expected_images.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_point_count(input logic [CNT_W-1:0] count);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= count;
    do @(posedge clk_i); while (!cfg_ready_o);
    points_cfg = count;
    cfg_valid_i <= 1'b0;
  endtask

  // loads a shuffled permutation of n points, sometimes with one bad value
  task automatic load_permutation(input logic [MODE_W-1:0] mode, input int n);
    int perm [TABLE_POINTS];
    int i;
    int j;
    int tmp;
    for (i = 0; i < n; i++) perm[i] = i;
    for (i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    if ($urandom_range(3) == 0) perm[$urandom_range(n - 1)] = $urandom_range(255);
    for (i = 0; i < n; i++) send_item(mode, i[VAL_W-1:0], perm[i][VAL_W-1:0]);
  endtask

  // one request of a random mode, indexes and values mostly in range
  task automatic random_item(input int n);
    int r;
    logic [MODE_W-1:0] mode;
    logic [VAL_W-1:0] idx;
    logic [VAL_W-1:0] val;
    r = $urandom_range(99);
    if (r < 20) mode = MODE_LOAD_OWN;
    else if (r < 35) mode = MODE_LOAD_OTHER;
    else if (r < 40) mode = MODE_IDENTITY;
    else if (r < 48) mode = MODE_INVERT;
    else if (r < 56) mode = MODE_COMPOSE;
    else if (r < 95) mode = MODE_QUERY;
    else if (r < 97) mode = MODE_SPARE_LO;
    else mode = MODE_SPARE_HI;
    if (n > 0 && $urandom_range(4) != 0) idx = VAL_W'($urandom_range(n - 1));
    else idx = VAL_W'($urandom_range(255));
    if (n > 0 && $urandom_range(9) < 7) val = VAL_W'($urandom_range(n - 1));
    else val = VAL_W'($urandom_range(255));
    send_item(mode, idx, val);
  endtask

  // every entry of both banks and the other table gets written at least once
  task automatic test_fill_tables;
    send_item(MODE_IDENTITY, 8'd0, 8'd0);
    send_item(MODE_INVERT, 8'd0, 8'd0);
    send_item(MODE_INVERT, 8'd0, 8'd0);
    load_permutation(MODE_LOAD_OTHER, TABLE_POINTS);
  endtask

  task automatic test_directed_cases;
    // four points: range limits, bad values, every mode
    write_point_count(9'd4);
    send_item(MODE_LOAD_OWN, 8'd0, 8'd3);
    send_item(MODE_LOAD_OWN, 8'd3, 8'd0);
    send_item(MODE_LOAD_OWN, 8'd4, 8'd1);
    send_item(MODE_LOAD_OWN, 8'd255, 8'd2);
    send_item(MODE_LOAD_OWN, 8'd1, 8'd255);
    send_item(MODE_LOAD_OTHER, 8'd0, 8'd255);
    send_item(MODE_LOAD_OTHER, 8'd3, 8'd0);
    send_item(MODE_LOAD_OTHER, 8'd4, 8'd1);
    send_item(MODE_QUERY, 8'd1, 8'd0);
    send_item(MODE_IDENTITY, 8'd0, 8'd0);
    send_item(MODE_QUERY, 8'd3, 8'd255);
    send_item(MODE_QUERY, 8'd4, 8'd0);
    send_item(MODE_QUERY, 8'd255, 8'd0);
    send_item(MODE_LOAD_OWN, 8'd2, 8'd200);
    send_item(MODE_INVERT, 8'd0, 8'd0);
    send_item(MODE_QUERY, 8'd2, 8'd0);
    send_item(MODE_COMPOSE, 8'd0, 8'd0);
    send_item(MODE_QUERY, 8'd0, 8'd0);
    send_item(MODE_SPARE_LO, 8'd255, 8'd255);
    send_item(MODE_SPARE_HI, 8'd0, 8'd0);
    // no points at all
    write_point_count(9'd0);
    send_item(MODE_LOAD_OWN, 8'd0, 8'd0);
    send_item(MODE_LOAD_OTHER, 8'd0, 8'd0);
    send_item(MODE_QUERY, 8'd0, 8'd0);
    send_item(MODE_IDENTITY, 8'd0, 8'd0);
    send_item(MODE_INVERT, 8'd0, 8'd0);
    send_item(MODE_COMPOSE, 8'd0, 8'd0);
    // count above the table size acts as the table size
    write_point_count(9'd511);
    send_item(MODE_QUERY, 8'd255, 8'd0);
    send_item(MODE_INVERT, 8'd0, 8'd0);
    send_item(MODE_QUERY, 8'd0, 8'd0);
  endtask

  // receiver holds off while requests keep coming
  task automatic test_backpressure;
    write_point_count(9'd16);
    hold_left = 200;
    repeat (40) random_item(16);
  endtask

  task automatic test_drain_pause;
    repeat (10) random_item(16);
    drain_results();
    repeat (10) random_item(16);
  endtask

  task automatic test_random_phases;
    int start;
    int phase;
    int n;
    logic [CNT_W-1:0] count;
    start = items_sent;
    phase = 0;
    while (items_sent - start < RANDOM_ITEMS || phase < 3) begin
      case (phase)
        0: count = 9'd1;
        1: count = 9'd256;
        2: count = 9'd2;
        default: begin
          case ($urandom_range(7))
            0: count = 9'd0;
            1: count = 9'd1;
            2: count = CNT_W'($urandom_range(3, 12));
            3: count = CNT_W'($urandom_range(13, 40));
            4: count = 9'd256;
            5: count = CNT_W'($urandom_range(257, 511));
            6: count = 9'd255;
            default: count = CNT_W'($urandom_range(1, 16));
          endcase
        end
      endcase
      write_point_count(count);
      n = active_count();
      calm = (phase == 2);
      if (n >= 1 && n <= 32) begin
        load_permutation(MODE_LOAD_OWN, n);
        load_permutation(MODE_LOAD_OTHER, n);
      end
      repeat ($urandom_range(15, 40)) random_item(n);
      phase++;
    end
    calm = 1'b0;
  endtask

  // result check and receiver idling
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_images.size() == 0) begin
        report_mismatch("result with nothing pending", int'(m_axis_tdata), 0);
      end else begin
        oldest = expected_images.pop_front();
        if (m_axis_tdata[7:0] !== oldest.image)
          report_mismatch("image_value", int'(m_axis_tdata[7:0]), int'(oldest.image));
        if (m_axis_tdata[8] !== oldest.status)
          report_mismatch("status", int'(m_axis_tdata[8]), int'(oldest.status));
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 27);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_tables();
    test_directed_cases();
    test_backpressure();
    test_drain_pause();
    test_random_phases();
    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_images.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
